>>> hw/rtl/hhc_pkg.sv
`default_nettype none
package hhc_pkg;
  localparam int TableEntriesDefault = 8192;
  localparam int ProbeCountDefault = 8;
  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;
  localparam int SlotIndexWidth = 13;
  localparam logic ModePut = 1'b0;
  localparam logic ModeGet = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [63:0] value_in;
    logic [47:0] now_ms;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] value_out;
    logic [12:0] slot_index;
    logic        evicted;
  } resp_t;

  // queued job: request plus its hash and the enable seen at accept
  typedef struct packed {
    req_t        req;
    logic [31:0] hash;
    logic        enable;
  } job_t;
endpackage
`default_nettype wire

>>> hw/rtl/hhc_req_if.sv
`default_nettype none
interface hhc_req_if;
  logic valid;
  logic ready;
  hhc_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/hhc_resp_if.sv
`default_nettype none
interface hhc_resp_if;
  logic valid;
  logic ready;
  hhc_pkg::resp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/hashed_host_cache_oldest_replace.sv
// Flow: the front hashes a word's 16 key bytes; the job goes through the queue to the table
// back end, which reads and checks each probed slot (SRead, SCheck), writes the slot for a
// put (SWrite), then offers the answer. The front takes no new word until its job enters the
// queue; the back end takes no job until its answer is taken and probes slots one by one.
// Reset: synchronous; after reset the back end clears the table valid bits in a pass of the
// SClear state over every slot, during which no word leaves the queue.
`default_nettype none
module hashed_host_cache_oldest_replace #(
  parameter int TableEntries = hhc_pkg::TableEntriesDefault,
  parameter int ProbeCount = hhc_pkg::ProbeCountDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  hhc_req_if.sink   req,
  hhc_resp_if.source resp
);
  import hhc_pkg::*;

  logic table_enable;
  logic fj_valid, fj_ready, bj_valid, bj_ready;
  job_t fj, bj;

  always_ff @(posedge clk) begin
    if (rst) table_enable <= 1'b0;
    else if (cfg_we) table_enable <= cfg_wdata;
  end

  hhc_front u_front (
    .clk, .rst, .table_enable,
    .in_valid(req.valid), .in_ready(req.ready), .in_req(req.payload),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  hhc_queue u_queue (
    .clk, .rst,
    .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
  );

  hhc_back #(.TableEntries(TableEntries), .ProbeCount(ProbeCount)) u_back (
    .clk, .rst,
    .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .out_valid(resp.valid), .out_ready(resp.ready), .out_resp(resp.payload)
  );
endmodule
`default_nettype wire

>>> hw/rtl/hhc_front.sv
`default_nettype none
// Accepts a request and folds the 16 key bytes one per cycle.
module hhc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          table_enable,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire hhc_pkg::req_t in_req,
  output logic               job_valid,
  input  wire logic          job_ready,
  output hhc_pkg::job_t      job
);
  import hhc_pkg::*;

  logic        busy;
  logic        done;
  logic [3:0]  cnt;
  logic [31:0] hash;
  req_t        req;
  logic        enable;
  logic [127:0] key;
  logic [7:0]  byte_sel;
  logic [31:0] mixed;

  assign key = {req.key_high, req.key_low};
  assign byte_sel = key[8'd127 - {1'b0, cnt, 3'd0} -: 8];
  assign mixed = (hash ^ {24'd0, byte_sel}) * FnvPrime;

  assign in_ready = !busy;
  assign job_valid = done;
  assign job = '{req: req, hash: hash, enable: enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt <= '0;
    end else if (busy && !done) begin
      cnt <= cnt + 4'd1;
      if (cnt == 4'd15) done <= 1'b1;
    end else if (done && job_ready) begin
      done <= 1'b0;
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_req;
      enable <= table_enable;
      hash <= FnvBasis;
    end else if (busy && !done) begin
      hash <= mixed;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/hhc_queue.sv
`default_nettype none
// Two-entry queue between hash front and table back.
module hhc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire hhc_pkg::job_t wr_job,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output hhc_pkg::job_t      rd_job
);
  import hhc_pkg::*;

  job_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       wr;
  logic       rd;

  assign wr_ready = fill != 2'd2;
  assign rd_valid = fill != 2'd0;
  assign rd_job = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= '0;
    end else begin
      if (wr) wp <= !wp;
      if (rd) rp <= !rp;
      fill <= fill + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_job;
  end
endmodule
`default_nettype wire

>>> hw/rtl/hhc_back.sv
`default_nettype none
// Probes slots in turn, writes the chosen slot for a put, then answers.
module hhc_back #(
  parameter int TableEntries = hhc_pkg::TableEntriesDefault,
  parameter int ProbeCount = hhc_pkg::ProbeCountDefault
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          job_valid,
  output logic               job_ready,
  input  wire hhc_pkg::job_t job,
  output logic               out_valid,
  input  wire logic          out_ready,
  output hhc_pkg::resp_t     out_resp
);
  import hhc_pkg::*;

  localparam int AW = $clog2(TableEntries);
  localparam int PW = $clog2(ProbeCount + 1);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SClear = 3'd1;
  localparam logic [2:0] SRead  = 3'd2;
  localparam logic [2:0] SCheck = 3'd3;
  localparam logic [2:0] SWrite = 3'd4;
  localparam logic [2:0] SOut   = 3'd5;

  typedef struct packed {
    logic        valid;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [63:0] value;
    logic [47:0] time_ms;
  } slot_t;

  slot_t mem [TableEntries];
  slot_t rdata;
  logic [2:0]    state;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] addr;
  logic [PW-1:0] probe;
  job_t          cur;
  logic          have;
  logic [47:0]   oldest;
  logic [AW-1:0] target;
  resp_t         resp;
  logic          match;
  logic          last;

  assign job_ready = state == SIdle;
  assign out_valid = state == SOut;
  assign out_resp = resp;
  assign match = rdata.valid && rdata.key_high == cur.req.key_high
                 && rdata.key_low == cur.req.key_low;
  assign last = probe == PW'(ProbeCount - 1);

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
    if (state == SClear) begin
      mem[clr_addr] <= '0;
    end else if (state == SWrite) begin
      mem[target] <= '{valid: 1'b1, key_high: cur.req.key_high,
                       key_low: cur.req.key_low, value: cur.req.value_in,
                       time_ms: cur.req.now_ms};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SClear;
      clr_addr <= '0;
    end else begin
      case (state)
        SClear: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(TableEntries - 1)) state <= SIdle;
        end
        SIdle: begin
          if (job_valid) begin
            cur <= job;
            addr <= job.hash[AW-1:0];
            probe <= '0;
            have <= 1'b0;
            resp <= '0;
            state <= job.enable ? SRead : SOut;
          end
        end
        SRead: state <= SCheck;
        SCheck: begin
          if (cur.req.mode == ModeGet) begin
            if (match) begin
              resp.hit <= 1'b1;
              resp.value_out <= rdata.value;
              resp.slot_index <= 13'(addr);
              state <= SOut;
            end else if (last) begin
              state <= SOut;
            end
          end else if (!rdata.valid || match) begin
            target <= addr;
            resp.hit <= rdata.valid;
            resp.slot_index <= 13'(addr);
            state <= SWrite;
          end else begin
            if (!have || rdata.time_ms < oldest) begin
              have <= 1'b1;
              oldest <= rdata.time_ms;
              target <= addr;
            end
            if (last) begin
              resp.evicted <= 1'b1;
              resp.slot_index <= (!have || rdata.time_ms < oldest)
                                 ? 13'(addr) : 13'(target);
              state <= SWrite;
            end
          end
          if (state == SCheck && !last) begin
            addr <= addr + AW'(1);
            probe <= probe + PW'(1);
          end
          if (!last && !(cur.req.mode == ModeGet && match)
              && !(cur.req.mode == ModePut && (!rdata.valid || match)))
            state <= SRead;
        end
        SWrite: state <= SOut;
        SOut: if (out_ready) state <= SIdle;
        default: state <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire
